/* hw/rtl/mfb_pkg.sv */
// Shared sizes, result codes and interface types of the monochrome frame buffer.
package mfb_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PIX_PER_BYTE  = 8;
   localparam int ROW_BYTES     = SCREEN_WIDTH / PIX_PER_BYTE;
   localparam int HALF_ROWS     = SCREEN_HEIGHT / 2;
   localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   localparam int CNT_W         = $clog2(2 * ROW_BYTES);
   // Distance from the end of the upper row to the start of its lower partner.
   localparam int HALF_JUMP     = 1 + (HALF_ROWS - 1) * ROW_BYTES;

   localparam logic [1:0] KIND_GFX_OFF = 2'd0;
   localparam logic [1:0] KIND_ADDR    = 2'd1;
   localparam logic [1:0] KIND_DATA    = 2'd2;
   localparam logic [1:0] KIND_GFX_ON  = 2'd3;

   localparam logic OP_PLOT = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] pixel_x;
      logic [6:0] pixel_y;
      logic       pixel_on;
      logic [4:0] scan_row;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic       clear_wr;
      logic       load;
      logic       plot_rd;
      logic       plot_wr;
      logic       scan_rd;
      logic       scan_jump;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

/* hw/rtl/mfb_ctrl.sv */
// Sequencer for the frame buffer: clearing pass, pixel read-modify-write and row readout.
module mfb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   item_op,
   input  mfb_pkg::dp_status_type status,
   output mfb_pkg::ctl_cmd_type   cmd,
   output logic                   busy
);

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_PLOT_RD   = 8'b0000_0100,
      ST_PLOT_WR   = 8'b0000_1000,
      ST_SCAN_OFF  = 8'b0001_0000,
      ST_SCAN_ADDR = 8'b0010_0000,
      ST_SCAN_DATA = 8'b0100_0000,
      ST_SCAN_ON   = 8'b1000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [mfb_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (item_op == mfb_pkg::OP_SCAN) ? ST_SCAN_OFF : ST_PLOT_RD;
            end
         end
         ST_PLOT_RD: begin
            cmd.plot_rd = 1'b1;
            state_in    = ST_PLOT_WR;
         end
         ST_PLOT_WR: begin
            cmd.plot_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN_OFF: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = mfb_pkg::KIND_GFX_OFF;
            state_in      = ST_SCAN_ADDR;
         end
         ST_SCAN_ADDR: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = mfb_pkg::KIND_ADDR;
            cmd.scan_rd   = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SCAN_DATA;
         end
         ST_SCAN_DATA: begin
            // Each cycle shows the byte fetched last cycle and fetches the next one.
            cmd.emit      = 1'b1;
            cmd.emit_kind = mfb_pkg::KIND_DATA;
            cmd.scan_rd   = 1'b1;
            cmd.scan_jump = (cnt_ff == mfb_pkg::CNT_W'(mfb_pkg::ROW_BYTES - 2));
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == mfb_pkg::CNT_W'(2 * mfb_pkg::ROW_BYTES - 1)) state_in = ST_SCAN_ON;
         end
         ST_SCAN_ON: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = mfb_pkg::KIND_GFX_ON;
            cmd.emit_last = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/mfb_datapath.sv */
// Frame store memory, address and mask logic, and the registered result word.
module mfb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mfb_pkg::req_item_type  req_item,
   input  mfb_pkg::ctl_cmd_type   cmd,
   output mfb_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output mfb_pkg::rsp_item_type  rsp_item
);

   localparam int AW = mfb_pkg::ADDR_W;

   logic [7:0]    mem [mfb_pkg::STORE_BYTES];

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] plot_addr_ff;
   logic [7:0]    plot_mask_ff;
   logic          plot_on_ff;
   logic          plot_ok_ff;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [7:0]    row_value_ff;
   logic [7:0]    rdata_ff;
   logic          rsp_strobe_ff;
   mfb_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [7:0]    x_cl;
   logic [6:0]    y_cl;
   logic [4:0]    row_cl;
   logic [AW:0]   plot_addr_full;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   always_comb begin
      x_cl = req_item.pixel_x;
      if ({1'b0, req_item.pixel_x} >= 9'(mfb_pkg::SCREEN_WIDTH))
         x_cl = 8'(mfb_pkg::SCREEN_WIDTH - 1);
      y_cl = req_item.pixel_y;
      if ({1'b0, req_item.pixel_y} >= 8'(mfb_pkg::SCREEN_HEIGHT))
         y_cl = 7'(mfb_pkg::SCREEN_HEIGHT - 1);
      row_cl = req_item.scan_row;
      if ({2'b00, req_item.scan_row} >= 7'(mfb_pkg::HALF_ROWS))
         row_cl = 5'(mfb_pkg::HALF_ROWS - 1);
      plot_addr_full = (AW + 1)'(y_cl) * (AW + 1)'(mfb_pkg::ROW_BYTES)
                     + (AW + 1)'(x_cl >> 3);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         plot_addr_ff <= plot_addr_full[AW-1:0];
         plot_ok_ff   <= (plot_addr_full < (AW + 1)'(mfb_pkg::STORE_BYTES));
         plot_mask_ff <= 8'h80 >> x_cl[2:0];
         plot_on_ff   <= req_item.pixel_on;
         row_value_ff <= 8'(row_cl);
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.load)
         scan_addr_in = AW'(row_cl) * AW'(mfb_pkg::ROW_BYTES);
      else if (cmd.scan_rd)
         scan_addr_in = cmd.scan_jump ? scan_addr_ff + AW'(mfb_pkg::HALF_JUMP)
                                      : scan_addr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
   end

   assign clr_addr_in       = cmd.clear_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;
   assign status.clear_last = (clr_addr_ff == AW'(mfb_pkg::STORE_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else       clr_addr_ff <= clr_addr_in;
   end

   // Single write port shared by the clearing pass and pixel updates.
   always_comb begin
      wr_en   = cmd.clear_wr || (cmd.plot_wr && plot_ok_ff);
      wr_addr = cmd.clear_wr ? clr_addr_ff : plot_addr_ff;
      if (cmd.clear_wr)
         wr_data = 8'h00;
      else if (plot_on_ff)
         wr_data = rdata_ff | plot_mask_ff;
      else
         wr_data = rdata_ff & ~plot_mask_ff;
   end

   assign rd_addr = cmd.plot_rd ? plot_addr_ff : scan_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      rsp_item_in.kind  = cmd.emit_kind;
      rsp_item_in.last  = cmd.emit_last;
      rsp_item_in.value = 8'h00;
      if (cmd.emit_kind == mfb_pkg::KIND_ADDR)      rsp_item_in.value = row_value_ff;
      else if (cmd.emit_kind == mfb_pkg::KIND_DATA) rsp_item_in.value = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

/* hw/rtl/mono_framebuffer_plot_and_scanout_top.sv */
// Top level of the 1 bpp frame buffer with pixel plotting and row-pair readout.
// A plot word passes through accept, memory read and memory write, and gives no result.
// A readout word gives 35 results, one a cycle, paced by the single registered read port;
// the first result comes after accept through the state register and the result register.
// After reset a clearing pass writes zeros over all STORE_BYTES entries with busy high;
// results cannot be held off by the receiver.
module mono_framebuffer_plot_and_scanout_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mfb_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output mfb_pkg::rsp_item_type rsp_item
);

   mfb_pkg::ctl_cmd_type   cmd;
   mfb_pkg::dp_status_type status;

   mfb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .item_op (req_item.op),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   mfb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTHESIS
   // An accepted word always occupies the block for at least the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   // The end-of-run flag only rides on the graphics-on result.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |-> (rsp_item.kind == mfb_pkg::KIND_GFX_ON))
      else $error("last flag on a result other than graphics on");

   // Graphics off is followed directly by the row address.
   a_off_then_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.kind == mfb_pkg::KIND_GFX_OFF)
      |=> (rsp_strobe && rsp_item.kind == mfb_pkg::KIND_ADDR))
      else $error("row address did not follow graphics off");
`endif

endmodule

/* dv/mono_framebuffer_plot_and_scanout_top_tb.sv */
// Self-checking testbench for the 1 bpp frame buffer: random plots and row-pair readouts.
module mono_framebuffer_plot_and_scanout_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_WORDS = 108;
   localparam int QUIET_WORDS  = 30;

   // Mirror of the frame store plus the queue of readout results still owed.
   class frame_scoreboard;
      logic [7:0]            frame_bytes [mfb_pkg::STORE_BYTES];
      mfb_pkg::rsp_item_type pending_results [$];
      int                    errors;
      int                    checked;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         errors  = 0;
         checked = 0;
      endfunction

      function void owe_result(input logic [1:0] kind, input logic [7:0] value,
                               input logic last);
         mfb_pkg::rsp_item_type r;
         r.kind  = kind;
         r.value = value;
         r.last  = last;
         pending_results.push_back(r);
      endfunction

      function void take_word(input mfb_pkg::req_item_type w);
         int         x;
         int         y;
         int         row;
         int         addr;
         logic [7:0] mask;
         if (w.op == mfb_pkg::OP_PLOT) begin
            x = w.pixel_x;
            y = w.pixel_y;
            if (x >= mfb_pkg::SCREEN_WIDTH) x = mfb_pkg::SCREEN_WIDTH - 1;
            if (y >= mfb_pkg::SCREEN_HEIGHT) y = mfb_pkg::SCREEN_HEIGHT - 1;
            addr = mfb_pkg::ROW_BYTES * y + x / mfb_pkg::PIX_PER_BYTE;
            mask = 8'h80 >> (x % mfb_pkg::PIX_PER_BYTE);
            if (w.pixel_on) frame_bytes[addr] = frame_bytes[addr] | mask;
            else frame_bytes[addr] = frame_bytes[addr] & ~mask;
         end else begin
            row = w.scan_row;
            if (row >= mfb_pkg::HALF_ROWS) row = mfb_pkg::HALF_ROWS - 1;
            owe_result(mfb_pkg::KIND_GFX_OFF, 8'h00, 1'b0);
            owe_result(mfb_pkg::KIND_ADDR, 8'(row), 1'b0);
            for (int c = 0; c < mfb_pkg::ROW_BYTES; c++)
               owe_result(mfb_pkg::KIND_DATA,
                          frame_bytes[row * mfb_pkg::ROW_BYTES + c], 1'b0);
            for (int c = 0; c < mfb_pkg::ROW_BYTES; c++)
               owe_result(mfb_pkg::KIND_DATA,
                          frame_bytes[(row + mfb_pkg::HALF_ROWS) * mfb_pkg::ROW_BYTES + c],
                          1'b0);
            owe_result(mfb_pkg::KIND_GFX_ON, 8'h00, 1'b1);
         end
      endfunction

      task report_mismatch(input string what);
         if (errors < 30) $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(input mfb_pkg::rsp_item_type got);
         mfb_pkg::rsp_item_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0d value=%02h last=%0b",
                                      got.kind, got.value, got.last));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
         if (got.value !== want.value)
            report_mismatch($sformatf("value %02h, wanted %02h (kind %0d)",
                                      got.value, want.value, want.kind));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   mfb_pkg::req_item_type req_item = '0;
   logic                  rsp_strobe;
   mfb_pkg::rsp_item_type rsp_item;

   frame_scoreboard sb;
   int              cycle_count = 0;
   int              plots_sent = 0;
   int              scans_sent = 0;

   mono_framebuffer_plot_and_scanout_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  sb.pending_results.size());
         $display("mono_framebuffer_plot_and_scanout_top_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_item);
   end

   function automatic mfb_pkg::req_item_type random_word(input bit scan);
      mfb_pkg::req_item_type w;
      w.op       = scan ? mfb_pkg::OP_SCAN : mfb_pkg::OP_PLOT;
      // Mostly on-screen coordinates so readouts see the plotted content.
      w.pixel_x  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                               : 8'($urandom_range(0, 127));
      w.pixel_y  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(64, 127))
                                               : 7'($urandom_range(0, 63));
      w.pixel_on = ($urandom_range(0, 4) != 0);
      w.scan_row = 5'($urandom_range(0, 31));
      return w;
   endfunction

   function automatic mfb_pkg::req_item_type plot_word(input int x, input int y,
                                                       input bit on);
      mfb_pkg::req_item_type w;
      w          = random_word(1'b0);
      w.pixel_x  = 8'(x);
      w.pixel_y  = 7'(y);
      w.pixel_on = on;
      return w;
   endfunction

   function automatic mfb_pkg::req_item_type scan_word(input int row);
      mfb_pkg::req_item_type w;
      w          = random_word(1'b1);
      w.scan_row = 5'(row);
      return w;
   endfunction

   // Presents a word and holds it until the block takes it.
   task automatic send_word(input mfb_pkg::req_item_type w);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sb.take_word(w);
      if (w.op == mfb_pkg::OP_PLOT) plots_sent++;
      else scans_sent++;
   endtask

   task automatic sender_gap(input int cycles);
      for (int i = 0; i < cycles; i++) begin
         @(negedge clock);
         start    <= 1'b0;
         req_item <= random_word(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained();
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corners, clamping, both halves of a row pair, clears.
      send_word(scan_word(0));
      send_word(plot_word(0, 0, 1'b1));
      send_word(plot_word(7, 0, 1'b1));
      send_word(plot_word(8, 0, 1'b1));
      send_word(plot_word(127, 0, 1'b1));
      send_word(plot_word(64, 32, 1'b1));
      sender_gap(3);
      send_word(plot_word(200, 5, 1'b1));
      send_word(plot_word(3, 100, 1'b1));
      send_word(plot_word(255, 127, 1'b1));
      send_word(plot_word(127, 63, 1'b1));
      send_word(scan_word(0));
      send_word(scan_word(31));
      send_word(scan_word(5));
      send_word(plot_word(0, 0, 1'b0));
      send_word(plot_word(255, 127, 1'b0));
      send_word(plot_word(7, 0, 1'b0));
      sender_gap(1);
      send_word(scan_word(0));
      send_word(scan_word(31));
      send_word(plot_word(0, 31, 1'b1));
      send_word(plot_word(255, 32, 1'b1));
      send_word(scan_word(31));
      send_word(scan_word(0));

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i < RANDOM_WORDS - QUIET_WORDS && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 18));
         send_word(random_word($urandom_range(0, 9) < 3));
      end
      sender_gap(1);
      wait_drained();

      $display("plotted %0d pixels and read out %0d row pairs", plots_sent, scans_sent);
      $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("mono_framebuffer_plot_and_scanout_top_tb OK");
      end else begin
         $display("mono_framebuffer_plot_and_scanout_top_tb NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_ctrl.sv
hw/rtl/mfb_datapath.sv
hw/rtl/mono_framebuffer_plot_and_scanout_top.sv
dv/mono_framebuffer_plot_and_scanout_top_tb.sv
